// ===== hdl/xsfwp_pkg.sv =====
// Shared types, codes and constants for the strobe framer with wake-up prediction.
package xsfwp_pkg;

  localparam int unsigned TICK_W      = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IVL_W       = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned FRAME_LEN_W = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned DIV_STEPS   = TICK_W;

  localparam int unsigned TABLE_ENTRIES_DEF = 8;

  localparam logic [FRAME_LEN_W-1:0] FRAME_BYTES = FRAME_LEN_W'(3);

  localparam logic [IVL_W-1:0]  WAKEUP_INTERVAL_RST = IVL_W'(1000);
  localparam logic [CNT_W-1:0]  STROBE_LIMIT_RST    = CNT_W'(10);
  localparam logic [BYTE_W-1:0] TYPE_STROBE_RST     = BYTE_W'(0);
  localparam logic [BYTE_W-1:0] TYPE_SACK_RST       = BYTE_W'(1);
  localparam logic [BYTE_W-1:0] TYPE_BROADCAST_RST  = BYTE_W'(2);

  typedef enum logic [1:0] {
    CMD_STROBE    = 2'd0,
    CMD_ACK       = 2'd1,
    CMD_BROADCAST = 2'd2,
    CMD_PARSE     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 2'd0,
    STS_FRAME_INV  = 2'd1,
    STS_ACK_INV    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID          = 3'd0,
    CFG_WAKEUP_INTERVAL = 3'd1,
    CFG_TRANSITION_TIME = 3'd2,
    CFG_TX_ADVANCE      = 3'd3,
    CFG_STROBE_LIMIT    = 3'd4,
    CFG_TYPE_STROBE     = 3'd5,
    CFG_TYPE_SACK       = 3'd6,
    CFG_TYPE_BROADCAST  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] wake;
    logic [CNT_W-1:0]  cnt;
  } ent_t;

  typedef struct packed {
    logic             start;
    logic [TICK_W-1:0] dividend;
    logic [IVL_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [IVL_W-1:0] rem;
  } rem_rsp_t;

endpackage

// ===== hdl/xsfwp_rem.sv =====
// Bit-serial restoring remainder unit: 32-bit dividend modulo 16-bit divisor.
module xsfwp_rem
  import xsfwp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [TICK_W-1:0] dvd_q;
  logic [IVL_W-1:0]  dsr_q;
  logic [IVL_W-1:0]  rem_q;
  logic [IVL_W-1:0]  rem_d;
  logic [IVL_W:0]    trial;

  always_comb begin
    trial = {rem_q, dvd_q[TICK_W-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = IVL_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = IVL_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hdl/xmac_strobe_framer_wake_predict.sv =====
// Top level: strobe/ack/broadcast framer and frame parser with neighbor wake-up prediction.
//
//  channel  | signals                                       | handshake
//  ---------+-----------------------------------------------+-------------------------
//  request  | command, dest_id, now_tick, rx_type, rx_id_*  | in_valid_i / in_ready_o
//  result   | frame_byte0..2, frame_len, tx_delay, status   | out_valid_o / out_ready_i
//  config   | cfg_idx_i, cfg_wdata_i                        | cfg_we_i, no wait
//
// Ack and broadcast builds and most parses go straight to the result stage. A strobe or an
// ack parse first scans the neighbor table entry by entry (read, then compare); a predicted
// strobe then also waits on the serial remainder unit before the table write.
// One request at a time; in_ready_o is high only while idle. A result waiting on
// out_ready_i holds back the end of the next request. Reset clears the table valid bits.
module xmac_strobe_framer_wake_predict
  import xsfwp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             command_i,
  input  logic [ID_W-1:0]        dest_id_i,
  input  logic [TICK_W-1:0]      now_tick_i,
  input  logic [BYTE_W-1:0]      rx_type_i,
  input  logic [BYTE_W-1:0]      rx_id_low_i,
  input  logic [BYTE_W-1:0]      rx_id_high_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [BYTE_W-1:0]      frame_byte0_o,
  output logic [BYTE_W-1:0]      frame_byte1_o,
  output logic [BYTE_W-1:0]      frame_byte2_o,
  output logic [FRAME_LEN_W-1:0] frame_len_o,
  output logic [TICK_W-1:0]      tx_delay_o,
  output logic [STATUS_W-1:0]    status_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD   = 7'b0000010,
    ST_CMP  = 7'b0000100,
    ST_PLAN = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_WR   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_e;

  // configuration
  logic [ID_W-1:0]   own_id_q;
  logic [IVL_W-1:0]  wakeup_interval_q;
  logic [IVL_W-1:0]  transition_time_q;
  logic [IVL_W-1:0]  tx_advance_q;
  logic [CNT_W-1:0]  strobe_limit_q;
  logic [BYTE_W-1:0] type_strobe_q;
  logic [BYTE_W-1:0] type_sack_q;
  logic [BYTE_W-1:0] type_broadcast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q          <= '0;
      wakeup_interval_q <= WAKEUP_INTERVAL_RST;
      transition_time_q <= '0;
      tx_advance_q      <= '0;
      strobe_limit_q    <= STROBE_LIMIT_RST;
      type_strobe_q     <= TYPE_STROBE_RST;
      type_sack_q       <= TYPE_SACK_RST;
      type_broadcast_q  <= TYPE_BROADCAST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OWN_ID:          own_id_q          <= cfg_wdata_i;
        CFG_WAKEUP_INTERVAL: wakeup_interval_q <= cfg_wdata_i;
        CFG_TRANSITION_TIME: transition_time_q <= cfg_wdata_i;
        CFG_TX_ADVANCE:      tx_advance_q      <= cfg_wdata_i;
        CFG_STROBE_LIMIT:    strobe_limit_q    <= cfg_wdata_i[CNT_W-1:0];
        CFG_TYPE_STROBE:     type_strobe_q     <= cfg_wdata_i[BYTE_W-1:0];
        CFG_TYPE_SACK:       type_sack_q       <= cfg_wdata_i[BYTE_W-1:0];
        CFG_TYPE_BROADCAST:  type_broadcast_q  <= cfg_wdata_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // control and request
  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [ID_W-1:0]   dest_q;
  logic [TICK_W-1:0] now_q;
  logic [IDX_W-1:0]  idx_q;
  logic              match_q, free_q;
  logic [IDX_W-1:0]  match_idx_q, free_idx_q;
  ent_t              match_ent_q, free_ent_q;

  // pending result
  logic [BYTE_W-1:0]      res_b0_q, res_b1_q, res_b2_q;
  logic [FRAME_LEN_W-1:0] res_len_q;
  logic [TICK_W-1:0]      res_delay_q;
  status_e                res_status_q;

  // neighbor table
  ent_t                     ent_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;
  ent_t                     rd_q;
  logic                     rd_vld_q;
  ent_t                     ent_cur;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  ent_t                     wr_data;

  // selected slot and strobe count update
  ent_t             sel;
  logic [CNT_W-1:0] cnt_next;

  // prediction
  rem_req_t         rem_req;
  rem_rsp_t         rem_rsp;
  logic [IVL_W-1:0] iv_eff;
  logic [IVL_W-1:0] base;
  logic [IVL_W-1:0] after_tt;
  logic [IVL_W-1:0] pred;

  logic [ID_W-1:0] rx_id;
  logic            in_fire;
  logic            out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rx_id      = {rx_id_high_i, rx_id_low_i};
  assign ent_cur    = rd_vld_q ? rd_q : '0;
  assign sel        = match_q ? match_ent_q : free_ent_q;
  assign cnt_next   = (sel.cnt > strobe_limit_q) ? '0 : sel.cnt + CNT_W'(1);
  assign iv_eff     = (wakeup_interval_q == '0) ? IVL_W'(1) : wakeup_interval_q;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_o || out_ready_i);

  always_comb begin
    base     = iv_eff - rem_rsp.rem;
    after_tt = base - transition_time_q;
    if (base < transition_time_q) begin
      pred = '0;
    end else if (after_tt > tx_advance_q) begin
      pred = after_tt - tx_advance_q;
    end else begin
      pred = after_tt;
    end
  end

  assign rem_req.start    = (state_q == ST_PLAN) && (cmd_q == CMD_STROBE) && match_q &&
                            (match_ent_q.wake != '0) && (match_ent_q.cnt == '0);
  assign rem_req.dividend = now_q - match_ent_q.wake;
  assign rem_req.divisor  = iv_eff;

  xsfwp_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = match_q ? match_idx_q : free_idx_q;
    wr_data = '{id: dest_q, wake: sel.wake, cnt: cnt_next};
    if (state_q == ST_WR) begin
      wr_en = 1'b1;
    end else if ((state_q == ST_PLAN) && (cmd_q == CMD_PARSE) && match_q) begin
      wr_en   = 1'b1;
      wr_data = '{id: dest_q, wake: now_q, cnt: '0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_data;
    end
    rd_q     <= ent_mem[idx_q];
    rd_vld_q <= vld_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (cmd_e'(command_i) == CMD_STROBE) begin
            state_d = ST_RD;
          end else if ((cmd_e'(command_i) == CMD_PARSE) && (rx_type_i != type_strobe_q) &&
                       (rx_type_i == type_sack_q) && (rx_id == dest_id_i)) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RD:   state_d = ST_CMP;
      ST_CMP:  state_d = (idx_q == IDX_W'(TABLE_ENTRIES - 1)) ? ST_PLAN : ST_RD;
      ST_PLAN: begin
        priority if (cmd_q == CMD_PARSE) begin
          state_d = ST_FIN;
        end else if (rem_req.start) begin
          state_d = ST_DIV;
        end else if (match_q || free_q) begin
          state_d = ST_WR;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV:  state_d = rem_rsp.done ? ST_WR : ST_DIV;
      ST_WR:   state_d = ST_FIN;
      ST_FIN:  state_d = out_load ? ST_IDLE : ST_FIN;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
      idx_q       <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (in_fire) begin
        idx_q   <= '0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (state_q == ST_CMP) begin
        if (idx_q != IDX_W'(TABLE_ENTRIES - 1)) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (!match_q && (ent_cur.id == dest_q)) begin
          match_q <= 1'b1;
        end
        if (!free_q && (ent_cur.id == '0)) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= cmd_e'(command_i);
      dest_q      <= dest_id_i;
      now_q       <= now_tick_i;
      res_delay_q <= '0;
      unique case (cmd_e'(command_i))
        CMD_STROBE: begin
          res_b0_q     <= type_strobe_q;
          res_b1_q     <= dest_id_i[BYTE_W-1:0];
          res_b2_q     <= dest_id_i[ID_W-1:BYTE_W];
          res_len_q    <= FRAME_BYTES;
          res_status_q <= STS_OK;
        end
        CMD_ACK: begin
          res_b0_q     <= type_sack_q;
          res_b1_q     <= own_id_q[BYTE_W-1:0];
          res_b2_q     <= own_id_q[ID_W-1:BYTE_W];
          res_len_q    <= FRAME_BYTES;
          res_status_q <= STS_OK;
        end
        CMD_BROADCAST: begin
          res_b0_q     <= type_broadcast_q;
          res_b1_q     <= '0;
          res_b2_q     <= '0;
          res_len_q    <= FRAME_BYTES;
          res_status_q <= STS_OK;
        end
        CMD_PARSE: begin
          res_b0_q  <= '0;
          res_b1_q  <= '0;
          res_b2_q  <= '0;
          res_len_q <= '0;
          priority if (rx_type_i == type_strobe_q) begin
            res_status_q <= (rx_id == own_id_q) ? STS_OK : STS_FRAME_INV;
          end else if (rx_type_i == type_sack_q) begin
            res_status_q <= (rx_id == dest_id_i) ? STS_OK : STS_ACK_INV;
          end else begin
            res_status_q <= STS_FRAME_INV;
          end
        end
        default: ;
      endcase
    end else begin
      if ((state_q == ST_CMP) && !match_q && (ent_cur.id == dest_q)) begin
        match_idx_q <= idx_q;
        match_ent_q <= ent_cur;
      end
      if ((state_q == ST_CMP) && !free_q && (ent_cur.id == '0)) begin
        free_idx_q <= idx_q;
        free_ent_q <= ent_cur;
      end
      if ((state_q == ST_DIV) && rem_rsp.done) begin
        res_delay_q <= TICK_W'(pred);
      end
    end
    if (out_load) begin
      frame_byte0_o <= res_b0_q;
      frame_byte1_o <= res_b1_q;
      frame_byte2_o <= res_b2_q;
      frame_len_o   <= res_len_q;
      tx_delay_o    <= res_delay_q;
      status_o      <= res_status_q;
    end
  end

endmodule

// ===== test/tb_xmac_strobe_framer_wake_predict.sv =====
// Testbench for the strobe framer with wake-up prediction: random requests, predicted frames.
module tb_xmac_strobe_framer_wake_predict;
  timeunit 1ns;
  timeprecision 1ps;
  import xsfwp_pkg::*;

  localparam int unsigned N_SLOTS      = TABLE_ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_REQS   = 250;

  typedef struct packed {
    cmd_e              cmd;
    logic [ID_W-1:0]   dest;
    logic [TICK_W-1:0] now;
    logic [BYTE_W-1:0] rx_type;
    logic [ID_W-1:0]   rx_id;
  } frame_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      b0;
    logic [BYTE_W-1:0]      b1;
    logic [BYTE_W-1:0]      b2;
    logic [FRAME_LEN_W-1:0] len;
    logic [TICK_W-1:0]      delay;
    status_e                status;
  } frame_rsp_t;

  logic                   clk_i;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i    = '0;
  logic [CFG_W-1:0]       cfg_wdata_i  = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             command_i    = '0;
  logic [ID_W-1:0]        dest_id_i    = '0;
  logic [TICK_W-1:0]      now_tick_i   = '0;
  logic [BYTE_W-1:0]      rx_type_i    = '0;
  logic [BYTE_W-1:0]      rx_id_low_i  = '0;
  logic [BYTE_W-1:0]      rx_id_high_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic [BYTE_W-1:0]      frame_byte0_o;
  logic [BYTE_W-1:0]      frame_byte1_o;
  logic [BYTE_W-1:0]      frame_byte2_o;
  logic [FRAME_LEN_W-1:0] frame_len_o;
  logic [TICK_W-1:0]      tx_delay_o;
  logic [STATUS_W-1:0]    status_o;

  // register shadows
  logic [ID_W-1:0]   own_id_q     = '0;
  logic [IVL_W-1:0]  interval_q   = WAKEUP_INTERVAL_RST;
  logic [CFG_W-1:0]  trans_q      = '0;
  logic [CFG_W-1:0]  advance_q    = '0;
  logic [CNT_W-1:0]  limit_q      = STROBE_LIMIT_RST;
  logic [BYTE_W-1:0] ty_strobe_q  = TYPE_STROBE_RST;
  logic [BYTE_W-1:0] ty_sack_q    = TYPE_SACK_RST;
  logic [BYTE_W-1:0] ty_bcast_q   = TYPE_BROADCAST_RST;

  // neighbor table shadow
  logic [ID_W-1:0]   nbr_id   [N_SLOTS];
  logic [TICK_W-1:0] nbr_wake [N_SLOTS];
  logic [CNT_W-1:0]  nbr_cnt  [N_SLOTS];

  frame_req_t  req_q[$];
  frame_rsp_t  frame_exp_q[$];
  frame_req_t  drv_req;
  frame_rsp_t  got_exp;
  logic [ID_W-1:0] dest_pool [10];
  logic [TICK_W-1:0] tick_now = '0;

  int unsigned mismatch_cnt = 0;
  int unsigned cyc_cnt      = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  int unsigned recv_hold    = 0;
  bit          req_taken    = 1'b0;
  bit          idle_on      = 1'b1;

  xmac_strobe_framer_wake_predict u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .dest_id_i     (dest_id_i),
    .now_tick_i    (now_tick_i),
    .rx_type_i     (rx_type_i),
    .rx_id_low_i   (rx_id_low_i),
    .rx_id_high_i  (rx_id_high_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_byte0_o (frame_byte0_o),
    .frame_byte1_o (frame_byte1_o),
    .frame_byte2_o (frame_byte2_o),
    .frame_len_o   (frame_len_o),
    .tx_delay_o    (tx_delay_o),
    .status_o      (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int find_entry(logic [ID_W-1:0] id);
    for (int i = 0; i < N_SLOTS; i++) begin
      if (nbr_id[i] == id) return i;
    end
    return -1;
  endfunction

  // frame, delay and status for one request; updates the table shadow
  function automatic frame_rsp_t predict_frame(frame_req_t r);
    frame_rsp_t       e;
    int               slot;
    logic [TICK_W-1:0] ivl;
    logic [TICK_W-1:0] base;
    logic [CNT_W-1:0] old;
    e        = '0;
    e.len    = FRAME_BYTES;
    e.status = STS_OK;
    case (r.cmd)
      CMD_STROBE: begin
        e.b0 = ty_strobe_q;
        e.b1 = r.dest[7:0];
        e.b2 = r.dest[15:8];
        slot = find_entry(r.dest);
        if (slot >= 0) begin
          if (nbr_wake[slot] != '0 && nbr_cnt[slot] == '0) begin
            ivl  = (interval_q == '0) ? TICK_W'(1) : TICK_W'(interval_q);
            base = ivl - ((r.now - nbr_wake[slot]) % ivl);
            if (base >= TICK_W'(trans_q)) begin
              base = base - TICK_W'(trans_q);
              if (base > TICK_W'(advance_q)) base = base - TICK_W'(advance_q);
            end else begin
              base = '0;
            end
            e.delay = base;
          end
        end else begin
          slot = find_entry('0);
          if (slot >= 0) nbr_id[slot] = r.dest;
        end
        if (slot >= 0) begin
          old           = nbr_cnt[slot];
          nbr_cnt[slot] = (old > limit_q) ? '0 : old + 1'b1;
        end
      end
      CMD_ACK: begin
        e.b0 = ty_sack_q;
        e.b1 = own_id_q[7:0];
        e.b2 = own_id_q[15:8];
      end
      CMD_BROADCAST: begin
        e.b0 = ty_bcast_q;
      end
      default: begin
        e.len = '0;
        if (r.rx_type == ty_strobe_q) begin
          e.status = (r.rx_id == own_id_q) ? STS_OK : STS_FRAME_INV;
        end else if (r.rx_type == ty_sack_q) begin
          if (r.rx_id == r.dest) begin
            slot = find_entry(r.dest);
            if (slot >= 0) begin
              nbr_wake[slot] = r.now;
              nbr_cnt[slot]  = '0;
            end
          end else begin
            e.status = STS_ACK_INV;
          end
        end else begin
          e.status = STS_FRAME_INV;
        end
      end
    endcase
    return e;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (!idle_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (req_q.size() > 0) begin
        drv_req = req_q.pop_front();
        command_i    <= drv_req.cmd;
        dest_id_i    <= drv_req.dest;
        now_tick_i   <= drv_req.now;
        rx_type_i    <= drv_req.rx_type;
        rx_id_low_i  <= drv_req.rx_id[7:0];
        rx_id_high_i <= drv_req.rx_id[15:8];
        in_valid_i   <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      frame_exp_q.push_back(predict_frame(drv_req));
      req_taken = 1'b1;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      out_ready_i <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      recv_stall = pick_gap();
    end
  end

  task automatic check_field(string name, logic [TICK_W-1:0] exp_v, logic [TICK_W-1:0] got_v);
    if (exp_v !== got_v) begin
      mismatch_cnt++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, got_v);
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_exp_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result expected none actual %h %h %h", $time,
                 frame_byte0_o, tx_delay_o, status_o);
      end else begin
        got_exp = frame_exp_q.pop_front();
        check_field("frame_byte0", TICK_W'(got_exp.b0), TICK_W'(frame_byte0_o));
        check_field("frame_byte1", TICK_W'(got_exp.b1), TICK_W'(frame_byte1_o));
        check_field("frame_byte2", TICK_W'(got_exp.b2), TICK_W'(frame_byte2_o));
        check_field("frame_len", TICK_W'(got_exp.len), TICK_W'(frame_len_o));
        check_field("tx_delay", got_exp.delay, tx_delay_o);
        check_field("status", TICK_W'(got_exp.status), TICK_W'(status_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_req(cmd_e c, logic [ID_W-1:0] d, logic [TICK_W-1:0] t,
                         logic [BYTE_W-1:0] ty, logic [ID_W-1:0] rid);
    frame_req_t r;
    r.cmd     = c;
    r.dest    = d;
    r.now     = t;
    r.rx_type = ty;
    r.rx_id   = rid;
    req_q.push_back(r);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_OWN_ID:          own_id_q    = val;
      CFG_WAKEUP_INTERVAL: interval_q  = val;
      CFG_TRANSITION_TIME: trans_q     = val;
      CFG_TX_ADVANCE:      advance_q   = val;
      CFG_STROBE_LIMIT:    limit_q     = val[7:0];
      CFG_TYPE_STROBE:     ty_strobe_q = val[7:0];
      CFG_TYPE_SACK:       ty_sack_q   = val[7:0];
      default:             ty_bcast_q  = val[7:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] own, logic [15:0] ivl, logic [15:0] tt,
                            logic [15:0] adv, logic [7:0] lim, logic [7:0] ts,
                            logic [7:0] tk, logic [7:0] tb);
    write_reg(CFG_OWN_ID, own);
    write_reg(CFG_WAKEUP_INTERVAL, ivl);
    write_reg(CFG_TRANSITION_TIME, tt);
    write_reg(CFG_TX_ADVANCE, adv);
    write_reg(CFG_STROBE_LIMIT, 16'(lim));
    write_reg(CFG_TYPE_STROBE, 16'(ts));
    write_reg(CFG_TYPE_SACK, 16'(tk));
    write_reg(CFG_TYPE_BROADCAST, 16'(tb));
  endtask

  task automatic random_config();
    logic [15:0] ivl;
    ivl = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 2000))
                                     : 16'($urandom_range(1, 65535));
    set_config(16'($urandom()), ivl, 16'($urandom_range(0, ivl)),
               16'($urandom_range(0, ivl)),
               8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(0, 253)),
               8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || frame_exp_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] pick_dest();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return dest_pool[$urandom_range(0, 9)];
    if (p < 90) return '0;
    return ID_W'($urandom());
  endfunction

  task automatic advance_tick();
    if ($urandom_range(0, 99) < 5) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(1, 3 * int'(interval_q) + 10);
  endtask

  // mostly strobe / ack / re-strobe cycles, the rest noise
  task automatic gen_random(int unsigned n);
    int unsigned   k;
    int unsigned   p;
    logic [ID_W-1:0] d;
    k = 0;
    while (k < n) begin
      p = $urandom_range(0, 99);
      if (p < 60) begin
        d = pick_dest();
        repeat ($urandom_range(1, 3)) begin
          advance_tick();
          add_req(CMD_STROBE, d, tick_now, 8'($urandom()), 16'($urandom()));
          k++;
        end
        advance_tick();
        add_req(CMD_PARSE, d, tick_now, ty_sack_q,
                ($urandom_range(0, 99) < 85) ? d : ID_W'($urandom()));
        k++;
        repeat ($urandom_range(1, 2)) begin
          advance_tick();
          add_req(CMD_STROBE, d, tick_now, 8'($urandom()), 16'($urandom()));
          k++;
        end
      end else if (p < 68) begin
        add_req(CMD_ACK, 16'($urandom()), $urandom(), 8'($urandom()), 16'($urandom()));
        k++;
      end else if (p < 76) begin
        add_req(CMD_BROADCAST, 16'($urandom()), $urandom(), 8'($urandom()), 16'($urandom()));
        k++;
      end else if (p < 88) begin
        add_req(CMD_PARSE, pick_dest(), $urandom(), ty_strobe_q,
                ($urandom_range(0, 1) != 0) ? own_id_q : ID_W'($urandom()));
        k++;
      end else begin
        add_req(cmd_e'($urandom_range(0, 3)), pick_dest(), $urandom(), 8'($urandom()),
                16'($urandom()));
        k++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      nbr_id[i]   = '0;
      nbr_wake[i] = '0;
      nbr_cnt[i]  = '0;
    end
    dest_pool[0] = 16'hFFFF;
    dest_pool[1] = 16'h0101;
    dest_pool[2] = 16'h0102;
    dest_pool[3] = 16'h0103;
    for (int i = 4; i < 10; i++) dest_pool[i] = ID_W'($urandom_range(1, 65535));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values of the registers, directed requests first
    add_req(CMD_STROBE, 16'h0000, 32'h0, 8'hFF, 16'hFFFF);
    add_req(CMD_STROBE, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 16'h0000);
    add_req(CMD_ACK, 16'h0000, 32'h0, 8'h00, 16'h0000);
    add_req(CMD_BROADCAST, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    add_req(CMD_PARSE, 16'h0000, 32'd1, TYPE_STROBE_RST, 16'h0000);
    add_req(CMD_PARSE, 16'h0000, 32'd2, TYPE_STROBE_RST, 16'hFFFF);
    add_req(CMD_PARSE, 16'hFFFF, 32'd5000, TYPE_SACK_RST, 16'hFFFF);
    add_req(CMD_PARSE, 16'hFFFF, 32'd5100, TYPE_SACK_RST, 16'h00FF);
    add_req(CMD_PARSE, 16'h4444, 32'd5200, TYPE_SACK_RST, 16'h4444);
    add_req(CMD_PARSE, 16'h0000, 32'd5300, 8'hFF, 16'h0000);
    add_req(CMD_STROBE, 16'hFFFF, 32'd7500, 8'h00, 16'h0000);
    add_req(CMD_STROBE, 16'hFFFF, 32'd7600, 8'h00, 16'h0000);
    add_req(CMD_STROBE, 16'h0101, 32'd100, 8'h00, 16'h0000);
    add_req(CMD_STROBE, 16'h0102, 32'd200, 8'h00, 16'h0000);
    add_req(CMD_STROBE, 16'h0103, 32'd300, 8'h00, 16'h0000);
    add_req(CMD_PARSE, 16'h0101, 32'd0, TYPE_SACK_RST, 16'h0101);
    add_req(CMD_STROBE, 16'h0101, 32'd12345, 8'h00, 16'h0000);
    add_req(CMD_PARSE, 16'h0102, 32'hFFFF_FF00, TYPE_SACK_RST, 16'h0102);
    add_req(CMD_STROBE, 16'h0102, 32'h0000_0100, 8'h00, 16'h0000);
    add_req(CMD_PARSE, 16'h0102, 32'd400, TYPE_BROADCAST_RST, 16'h0102);
    gen_random(PHASE_REQS - 50);
    wait_idle();

    for (int ph = 1; ph < 9; ph++) begin
      idle_on = (ph != 2 && ph != 5);
      case (ph)
        1: set_config(16'hFFFF, 16'd1, 16'd0, 16'd0, 8'd0, 8'hFF, 8'h00, 8'h80);
        2: set_config(16'h0000, 16'd0, 16'd0, 16'hFFFF, 8'd253, 8'h5A, 8'hA5, 8'h00);
        3: set_config(16'h8001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd3, 8'h3C, 8'h3C, 8'h3C);
        default: random_config();
      endcase
      gen_random(PHASE_REQS);
      if (ph == 4) recv_hold = 400;
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
